// ===== rtl/free_list_heap_allocator_unit_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef FREE_LIST_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_LIST_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FLHA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Antecedent implies consequent in the next cycle.
`define FLHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== rtl/flha_pkg.sv =====
// Package with constants, codes and types of the free-list heap allocator.
package flha_pkg;

  localparam int HEAP_WORDS = 1024;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int LINK_W     = ADDR_W + 1;
  localparam int ALU_W      = LINK_W + 1;

  localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(HEAP_WORDS);
  localparam logic [LINK_W-1:0] LAST_HDR  = LINK_W'(HEAP_WORDS - 1);

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_ADD1,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
    logic             eq;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RESP,
    A_RS, A_RL, A_PICK, A_NXT, A_NB2, A_LINK, A_GRANT,
    F_MARK, F_SIZE, F_CMP, F_WALK, F_L0, F_M0, F_M1, F_M2, F_M3,
    F_P0, F_P1, F_P2, F_P3
  } state_t;

  // A link names a block only if its first payload word lies inside the heap.
  function automatic logic is_block(input logic [LINK_W-1:0] b);
    return b < LAST_HDR;
  endfunction

endpackage

// ===== rtl/free_list_heap_allocator_unit.sv =====
// Top level of the free-list heap allocator: sequencer, heap memory and mark memory.
// An allocate walks the free list block by block, then relinks it and writes the grant header,
//   first splitting off a new free block when the remainder allows; a free walks the free blocks
//   below it, then merges with its neighbors; the single-port heap memory and the shared adder pace both.
// Throughput: one request at a time; the next is taken once the result has moved into the output register.
// Reset: synchronous, active low; a clearing pass over all 1024 words follows, and takes no request.
`include "free_list_heap_allocator_unit_macros.svh"

module free_list_heap_allocator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [9:0] in_req_size,
  input  logic [9:0] in_free_addr,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [9:0] out_alloc_addr,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_fit_policy
);

  localparam int AW = flha_pkg::ADDR_W;
  localparam int LW = flha_pkg::LINK_W;
  localparam int XW = flha_pkg::ALU_W;

  // The heap memory holds one header or link word per entry. Every cycle it
  // reads at heap_addr and may write there too; the read data is registered and lands in the next cycle.
  logic [LW-1:0] heap_mem [flha_pkg::HEAP_WORDS];
  logic          mark_mem [flha_pkg::HEAP_WORDS];

  logic [AW-1:0] heap_addr;
  logic          heap_we;
  logic [LW-1:0] heap_wdata;
  logic [LW-1:0] heap_rd_r;
  logic [AW-1:0] mark_addr;
  logic          mark_we;
  logic          mark_wdata;
  logic          mark_rd_r;

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_addr] <= heap_wdata;
    end
    heap_rd_r <= heap_mem[heap_addr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_wdata;
    end
    mark_rd_r <= mark_mem[mark_addr];
  end

  // Most of the size and address arithmetic of the sequencer goes through this one unit.
  flha_pkg::alu_req_t alu_req;
  flha_pkg::alu_rsp_t alu_rsp;

  flha_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  flha_pkg::state_t state_r, state_nxt;

  logic [1:0]    policy_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic          empty_r, empty_nxt;

  // Walk registers: current block, its predecessor, the chosen block and sizes.
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] pick_r, pick_nxt;
  logic [LW-1:0] pick_prev_r, pick_prev_nxt;
  logic [LW-1:0] pick_size_r, pick_size_nxt;
  logic [LW-1:0] s_r, s_nxt;
  logic [LW-1:0] size_r, size_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] nxt_r, nxt_nxt;
  logic [LW-1:0] nb_r, nb_nxt;
  logic [LW-1:0] repl_r, repl_nxt;
  logic [LW-1:0] grant_r, grant_nxt;
  logic [LW-1:0] hdr_r, hdr_nxt;
  logic [LW-1:0] next_r, next_nxt;
  logic [LW-1:0] hlink_r, hlink_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          fit_r, fit_nxt;

  // The result waits here until the output register is free.
  flha_pkg::status_t res_status_r, res_status_nxt;
  logic [AW-1:0]     res_addr_r, res_addr_nxt;

  logic              out_valid_r, out_valid_nxt;
  flha_pkg::status_t out_status_r, out_status_nxt;
  logic [AW-1:0]     out_addr_r, out_addr_nxt;

  logic scan_first;
  logic take;

  assign in_ready       = (state_r == flha_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_addr = out_addr_r;
  assign cfg_ready      = 1'b1;

  // Any code other than best or worst fit searches first fit.
  assign scan_first = (policy_r != flha_pkg::POL_BEST) && (policy_r != flha_pkg::POL_WORST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= flha_pkg::POL_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      policy_r <= cfg_fit_policy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flha_pkg::S_CLR;
      clr_r       <= '0;
      head_r      <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    pick_r       <= pick_nxt;
    pick_prev_r  <= pick_prev_nxt;
    pick_size_r  <= pick_size_nxt;
    s_r          <= s_nxt;
    size_r       <= size_nxt;
    rem_r        <= rem_nxt;
    nxt_r        <= nxt_nxt;
    nb_r         <= nb_nxt;
    repl_r       <= repl_nxt;
    grant_r      <= grant_nxt;
    hdr_r        <= hdr_nxt;
    next_r       <= next_nxt;
    hlink_r      <= hlink_nxt;
    addr_r       <= addr_nxt;
    fit_r        <= fit_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    head_nxt       = head_r;
    empty_nxt      = empty_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    pick_nxt       = pick_r;
    pick_prev_nxt  = pick_prev_r;
    pick_size_nxt  = pick_size_r;
    s_nxt          = s_r;
    size_nxt       = size_r;
    rem_nxt        = rem_r;
    nxt_nxt        = nxt_r;
    nb_nxt         = nb_r;
    repl_nxt       = repl_r;
    grant_nxt      = grant_r;
    hdr_nxt        = hdr_r;
    next_nxt       = next_r;
    hlink_nxt      = hlink_r;
    addr_nxt       = addr_r;
    fit_nxt        = fit_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    heap_addr  = '0;
    heap_we    = 1'b0;
    heap_wdata = '0;
    mark_addr  = '0;
    mark_we    = 1'b0;
    mark_wdata = 1'b0;
    take       = 1'b0;

    alu_req.op = flha_pkg::ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;

    unique case (state_r)
      flha_pkg::S_CLR: begin
        // Rebuild the heap as one free block and clear every mark, a word a cycle.
        heap_we    = 1'b1;
        heap_addr  = clr_r;
        mark_we    = 1'b1;
        mark_addr  = clr_r;
        mark_wdata = 1'b0;
        if (clr_r == AW'(0)) begin
          heap_wdata = flha_pkg::LAST_HDR;
        end else if (clr_r == AW'(1)) begin
          heap_wdata = flha_pkg::LINK_END;
        end else begin
          heap_wdata = '0;
        end
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(flha_pkg::HEAP_WORDS - 1)) begin
          state_nxt = flha_pkg::S_IDLE;
        end
      end

      flha_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == flha_pkg::OP_ALLOC) begin
            // A zero size asks for one word.
            size_nxt = (in_req_size == '0) ? LW'(1) : LW'(in_req_size);
            cur_nxt  = empty_r ? flha_pkg::LINK_END : head_r;
            prev_nxt = flha_pkg::LINK_END;
            pick_nxt = flha_pkg::LINK_END;
            if (flha_pkg::is_block(cur_nxt)) begin
              heap_addr = cur_nxt[AW-1:0];
              state_nxt = flha_pkg::A_RS;
            end else begin
              state_nxt = flha_pkg::A_PICK;
            end
          end else begin
            addr_nxt  = AW'(in_free_addr);
            hdr_nxt   = LW'(in_free_addr) - LW'(1);
            mark_addr = AW'(in_free_addr);
            if (in_free_addr == '0) begin
              res_status_nxt = flha_pkg::ST_BADADDR;
              res_addr_nxt   = '0;
              state_nxt      = flha_pkg::S_RESP;
            end else begin
              state_nxt = flha_pkg::F_MARK;
            end
          end
        end
      end

      flha_pkg::A_RS: begin
        // Header of the current block is here; check it against the request.
        s_nxt      = heap_rd_r;
        alu_req.op = flha_pkg::ALU_SUB;
        alu_req.a  = XW'(heap_rd_r);
        alu_req.b  = XW'(size_r);
        fit_nxt    = !alu_rsp.lt;
        heap_addr  = AW'(cur_r + LW'(1));
        state_nxt  = flha_pkg::A_RL;
      end

      flha_pkg::A_RL: begin
        // Link word is here; weigh the block against the best candidate so far.
        alu_req.op = flha_pkg::ALU_SUB;
        alu_req.a  = XW'(s_r);
        alu_req.b  = XW'(pick_size_r);
        take = fit_r && ((pick_r == flha_pkg::LINK_END) ||
                         ((policy_r == flha_pkg::POL_BEST) && alu_rsp.lt) ||
                         ((policy_r == flha_pkg::POL_WORST) && !alu_rsp.lt && !alu_rsp.eq));
        if (take) begin
          pick_nxt      = cur_r;
          pick_prev_nxt = prev_r;
          pick_size_nxt = s_r;
        end
        if (fit_r && scan_first) begin
          state_nxt = flha_pkg::A_PICK;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = heap_rd_r;
          if (flha_pkg::is_block(heap_rd_r)) begin
            heap_addr = heap_rd_r[AW-1:0];
            state_nxt = flha_pkg::A_RS;
          end else begin
            state_nxt = flha_pkg::A_PICK;
          end
        end
      end

      flha_pkg::A_PICK: begin
        if (pick_r == flha_pkg::LINK_END) begin
          res_status_nxt = flha_pkg::ST_NOFIT;
          res_addr_nxt   = '0;
          state_nxt      = flha_pkg::S_RESP;
        end else begin
          alu_req.op = flha_pkg::ALU_SUB;
          alu_req.a  = XW'(pick_size_r);
          alu_req.b  = XW'(size_r);
          rem_nxt    = alu_rsp.sum[LW-1:0];
          heap_addr  = AW'(pick_r + LW'(1));
          state_nxt  = flha_pkg::A_NXT;
        end
      end

      flha_pkg::A_NXT: begin
        nxt_nxt = heap_rd_r;
        if (rem_r >= LW'(2)) begin
          // Split: the remainder becomes a new free block right after the grant.
          alu_req.op = flha_pkg::ALU_ADD1;
          alu_req.a  = XW'(pick_r);
          alu_req.b  = XW'(size_r);
          nb_nxt     = alu_rsp.sum[LW-1:0];
          heap_we    = 1'b1;
          heap_addr  = alu_rsp.sum[AW-1:0];
          heap_wdata = rem_r - LW'(1);
          state_nxt  = flha_pkg::A_NB2;
        end else begin
          repl_nxt  = heap_rd_r;
          grant_nxt = pick_size_r;
          state_nxt = flha_pkg::A_LINK;
        end
      end

      flha_pkg::A_NB2: begin
        heap_we    = 1'b1;
        heap_addr  = AW'(nb_r + LW'(1));
        heap_wdata = nxt_r;
        repl_nxt   = nb_r;
        grant_nxt  = size_r;
        state_nxt  = flha_pkg::A_LINK;
      end

      flha_pkg::A_LINK: begin
        if (pick_prev_r == flha_pkg::LINK_END) begin
          if (flha_pkg::is_block(repl_r)) begin
            head_nxt = repl_r;
          end else begin
            empty_nxt = 1'b1;
          end
        end else begin
          heap_we    = 1'b1;
          heap_addr  = AW'(pick_prev_r + LW'(1));
          heap_wdata = flha_pkg::is_block(repl_r) ? repl_r : flha_pkg::LINK_END;
        end
        state_nxt = flha_pkg::A_GRANT;
      end

      flha_pkg::A_GRANT: begin
        heap_we        = 1'b1;
        heap_addr      = pick_r[AW-1:0];
        heap_wdata     = grant_r;
        mark_we        = 1'b1;
        mark_addr      = AW'(pick_r + LW'(1));
        mark_wdata     = 1'b1;
        res_status_nxt = flha_pkg::ST_OK;
        res_addr_nxt   = AW'(pick_r + LW'(1));
        state_nxt      = flha_pkg::S_RESP;
      end

      flha_pkg::F_MARK: begin
        if (!mark_rd_r) begin
          res_status_nxt = flha_pkg::ST_BADADDR;
          res_addr_nxt   = '0;
          state_nxt      = flha_pkg::S_RESP;
        end else begin
          mark_we    = 1'b1;
          mark_addr  = addr_r;
          mark_wdata = 1'b0;
          heap_addr  = hdr_r[AW-1:0];
          state_nxt  = flha_pkg::F_SIZE;
        end
      end

      flha_pkg::F_SIZE: begin
        size_nxt  = heap_rd_r;
        cur_nxt   = empty_r ? flha_pkg::LINK_END : head_r;
        prev_nxt  = flha_pkg::LINK_END;
        next_nxt  = flha_pkg::LINK_END;
        state_nxt = flha_pkg::F_CMP;
      end

      flha_pkg::F_CMP: begin
        // Find the free neighbors on either side of the released block.
        alu_req.op = flha_pkg::ALU_SUB;
        alu_req.a  = XW'(cur_r);
        alu_req.b  = XW'(hdr_r);
        if (!flha_pkg::is_block(cur_r)) begin
          state_nxt = flha_pkg::F_L0;
        end else if (alu_rsp.lt) begin
          prev_nxt  = cur_r;
          heap_addr = AW'(cur_r + LW'(1));
          state_nxt = flha_pkg::F_WALK;
        end else begin
          if (!alu_rsp.eq) begin
            next_nxt = cur_r;
          end
          state_nxt = flha_pkg::F_L0;
        end
      end

      flha_pkg::F_WALK: begin
        cur_nxt   = heap_rd_r;
        state_nxt = flha_pkg::F_CMP;
      end

      flha_pkg::F_L0: begin
        heap_we    = 1'b1;
        heap_addr  = AW'(hdr_r + LW'(1));
        heap_wdata = next_r;
        hlink_nxt  = next_r;
        alu_req.op = flha_pkg::ALU_ADD1;
        alu_req.a  = XW'(hdr_r);
        alu_req.b  = XW'(size_r);
        if ((next_r != flha_pkg::LINK_END) && (alu_rsp.sum == XW'(next_r))) begin
          state_nxt = flha_pkg::F_M0;
        end else begin
          state_nxt = flha_pkg::F_P0;
        end
      end

      flha_pkg::F_M0: begin
        heap_addr = next_r[AW-1:0];
        state_nxt = flha_pkg::F_M1;
      end

      flha_pkg::F_M1: begin
        // Absorb the following free block.
        alu_req.op = flha_pkg::ALU_ADD1;
        alu_req.a  = XW'(size_r);
        alu_req.b  = XW'(heap_rd_r);
        size_nxt   = alu_rsp.sum[LW-1:0];
        heap_addr  = AW'(next_r + LW'(1));
        state_nxt  = flha_pkg::F_M2;
      end

      flha_pkg::F_M2: begin
        hlink_nxt  = heap_rd_r;
        heap_we    = 1'b1;
        heap_addr  = hdr_r[AW-1:0];
        heap_wdata = size_r;
        state_nxt  = flha_pkg::F_M3;
      end

      flha_pkg::F_M3: begin
        heap_we    = 1'b1;
        heap_addr  = AW'(hdr_r + LW'(1));
        heap_wdata = hlink_r;
        state_nxt  = flha_pkg::F_P0;
      end

      flha_pkg::F_P0: begin
        res_status_nxt = flha_pkg::ST_OK;
        res_addr_nxt   = '0;
        if (prev_r == flha_pkg::LINK_END) begin
          head_nxt  = hdr_r;
          empty_nxt = 1'b0;
          state_nxt = flha_pkg::S_RESP;
        end else begin
          heap_addr = prev_r[AW-1:0];
          state_nxt = flha_pkg::F_P1;
        end
      end

      flha_pkg::F_P1: begin
        s_nxt      = heap_rd_r;
        alu_req.op = flha_pkg::ALU_ADD1;
        alu_req.a  = XW'(prev_r);
        alu_req.b  = XW'(heap_rd_r);
        if (alu_rsp.sum == XW'(hdr_r)) begin
          state_nxt = flha_pkg::F_P2;
        end else begin
          heap_we    = 1'b1;
          heap_addr  = AW'(prev_r + LW'(1));
          heap_wdata = hdr_r;
          state_nxt  = flha_pkg::S_RESP;
        end
      end

      flha_pkg::F_P2: begin
        // The preceding free block absorbs the released one.
        alu_req.op = flha_pkg::ALU_ADD1;
        alu_req.a  = XW'(s_r);
        alu_req.b  = XW'(size_r);
        heap_we    = 1'b1;
        heap_addr  = prev_r[AW-1:0];
        heap_wdata = alu_rsp.sum[LW-1:0];
        state_nxt  = flha_pkg::F_P3;
      end

      flha_pkg::F_P3: begin
        heap_we    = 1'b1;
        heap_addr  = AW'(prev_r + LW'(1));
        heap_wdata = hlink_r;
        state_nxt  = flha_pkg::S_RESP;
      end

      flha_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = flha_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = flha_pkg::S_IDLE;
      end
    endcase
  end

  // A taken request always leaves the idle state.
  `FLHA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, state_r != flha_pkg::S_IDLE)
  // No request is taken during the clearing pass.
  `FLHA_ASSERT_SAME(a_no_req_in_clear, state_r == flha_pkg::S_CLR, !in_ready)
  // A new result appears only out of the response state.
  `FLHA_ASSERT_SAME(a_result_source, out_valid_r && !$past(out_valid_r),
                    $past(state_r) == flha_pkg::S_RESP)
  // A failed request never grants an address.
  `FLHA_ASSERT_SAME(a_fail_no_addr, out_valid_r && (out_status_r != flha_pkg::ST_OK),
                    out_addr_r == '0)

endmodule

// ===== rtl/flha_alu.sv =====
// Shared adder and comparator used by the allocator sequencer.
module flha_alu (
  input  flha_pkg::alu_req_t req,
  output flha_pkg::alu_rsp_t rsp
);

  logic [flha_pkg::ALU_W:0]   full;
  logic [flha_pkg::ALU_W-1:0] b_in;
  logic                       cin;

  always_comb begin
    b_in = req.b;
    cin  = 1'b0;
    unique case (req.op)
      flha_pkg::ALU_ADD: begin
        cin = 1'b0;
      end
      flha_pkg::ALU_ADD1: begin
        cin = 1'b1;
      end
      flha_pkg::ALU_SUB: begin
        b_in = ~req.b;
        cin  = 1'b1;
      end
      default: begin
        cin = 1'b0;
      end
    endcase
    full    = {1'b0, req.a} + {1'b0, b_in} + {{flha_pkg::ALU_W{1'b0}}, cin};
    rsp.sum = full[flha_pkg::ALU_W-1:0];
    // In subtract mode a missing carry means a < b.
    rsp.lt  = !full[flha_pkg::ALU_W];
    rsp.eq  = (full[flha_pkg::ALU_W-1:0] == '0);
  end

endmodule
